>>> rtl/tpss_pkg.sv
// shared types, constants and helpers for the triangle plane slice segment unit
package tpss_pkg;

  // coordinate and arithmetic widths
  localparam int CoordW   = 32;
  localparam int MagW     = 32;
  localparam int ProdW    = 2 * MagW;
  localparam int SumW     = ProdW + 2;
  localparam int PpmW     = 32;
  localparam int PpmFrac  = 16;
  localparam int DimW     = 15;
  localparam int TolW     = 16;
  localparam int Tol2W    = 2 * TolW;
  localparam int MapW     = CoordW + PpmW + 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // pipeline shape: three front stages, one divider stage per quotient bit, eight back stages
  localparam int DivSteps = MagW;
  localparam int Latency  = 3 + DivSteps + 8;

  // register reset values
  localparam logic [PpmW-1:0] PpmReset = 32'd1310720;
  localparam logic [DimW-1:0] DimReset = 15'd1024;
  localparam logic [TolW-1:0] TolReset = 16'd1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // per-triangle data carried alongside the dividers
  typedef struct packed {
    point_t [2:0] v;
    coord_t       pz;
    logic [2:0]   on;
    logic [2:0]   below;
    logic [2:0]   sx;
    logic [2:0]   sy;
  } carry_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXELS_PER_MM   = 2'd0,
    CFG_IMAGE_WIDTH     = 2'd1,
    CFG_IMAGE_HEIGHT    = 2'd2,
    CFG_PLANE_TOLERANCE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PAIR_01 = 2'd0,
    PAIR_02 = 2'd1,
    PAIR_12 = 2'd2
  } pair_e;

  // magnitude of a - b
  function automatic mag_t abs_diff(coord_t a, coord_t b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[CoordW]) begin
      d = ~d + 1'b1;
    end
    return d[MagW-1:0];
  endfunction

  // second vertex of edge k
  function automatic int next_vtx(int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

  // candidate slots of a pair
  function automatic int pair_first(int p);
    return (p == 2) ? 1 : 0;
  endfunction

  function automatic int pair_second(int p);
    return (p == 0) ? 1 : 2;
  endfunction

endpackage

>>> rtl/tpss_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module tpss_div_pipe #(
  parameter int Width = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*Width-1:0] num_i,
  input  logic [Width-1:0]   den_i,
  output logic [Width-1:0]   quo_o
);

  logic [Width-1:0] rem_q [Width];
  logic [Width-1:0] lo_q  [Width];
  logic [Width-1:0] den_q [Width];

  for (genvar k = 0; k < Width; k++) begin : g_step
    logic [Width-1:0] rem_in, lo_in, den_in;
    logic [Width:0]   trial, diff;
    logic             ge;

    // stage inputs: numerator halves at the head, previous stage elsewhere
    if (k == 0) begin : g_head
      assign rem_in = num_i[2*Width-1:Width];
      assign lo_in  = num_i[Width-1:0];
      assign den_in = den_i;
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
    end

    // shift in one numerator bit and try the subtract
    assign trial = {rem_in, lo_in[Width-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[Width-1:0] : trial[Width-1:0];
        lo_q[k]  <= {lo_in[Width-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = lo_q[Width-1];

endmodule

>>> rtl/triangle_plane_slice_segment_unit.sv
// triangle against horizontal plane: farthest intersection pair mapped to pixel space
// depth: 3 front stages, 32 divider stages and 8 back stages from input transfer to result;
//   the 32-stage crossing-point divider sets the depth
// throughput: one triangle per cycle; the whole pipeline holds while a result is not taken
// reset: clears all stage valid bits and loads the register defaults
module triangle_plane_slice_segment_unit import tpss_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // triangle input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  vertex_a_x_i,
  input  logic signed [31:0]  vertex_a_y_i,
  input  logic signed [31:0]  vertex_a_z_i,
  input  logic signed [31:0]  vertex_b_x_i,
  input  logic signed [31:0]  vertex_b_y_i,
  input  logic signed [31:0]  vertex_b_z_i,
  input  logic signed [31:0]  vertex_c_x_i,
  input  logic signed [31:0]  vertex_c_y_i,
  input  logic signed [31:0]  vertex_c_z_i,
  input  logic signed [31:0]  plane_z_i,
  // segment output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o,
  output logic signed [31:0]  start_col_o,
  output logic signed [31:0]  start_row_o,
  output logic signed [31:0]  end_col_o,
  output logic signed [31:0]  end_row_o
);

  localparam int OffW = DimW + FRAC_BITS - 1;
  localparam int ShW  = MapW - PpmFrac;
  localparam int RW   = ((OffW > ShW) ? OffW : ShW) + 2;
  localparam logic signed [RW-1:0] SatHi = RW'(2147483647);
  localparam logic signed [RW-1:0] SatLo = -SatHi - 1;

  // configuration registers
  logic [PpmW-1:0]  ppm_q;
  logic [DimW-1:0]  width_q, height_q;
  logic [TolW-1:0]  tol_q;
  logic [Tol2W-1:0] tol2_q, tol_sq;

  assign cfg_ready_o = 1'b1;
  assign tol_sq      = cfg_data_i[TolW-1:0] * cfg_data_i[TolW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q    <= PpmReset;
      width_q  <= DimReset;
      height_q <= DimReset;
      tol_q    <= TolReset;
      tol2_q   <= Tol2W'(TolReset) * Tol2W'(TolReset);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PIXELS_PER_MM:   ppm_q    <= cfg_data_i[PpmW-1:0];
        CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i[DimW-1:0];
        CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i[DimW-1:0];
        CFG_PLANE_TOLERANCE: begin
          tol_q  <= cfg_data_i[TolW-1:0];
          tol2_q <= tol_sq;
        end
        default: ;
      endcase
    end
  end

  // pipeline control: every stage moves unless a result sits unaccepted
  logic               en;
  logic [Latency-1:0] vld_q;

  assign en          = !vld_q[Latency-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Latency-2:0], in_valid_i};
    end
  end

  // stage 1: input capture
  point_t s1_v_q [3];
  coord_t s1_pz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_q[0] <= {vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
      s1_v_q[1] <= {vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
      s1_v_q[2] <= {vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};
      s1_pz_q   <= plane_z_i;
    end
  end

  // stage 2: plane distances and edge spans
  point_t     s2_v_q [3];
  coord_t     s2_pz_q;
  mag_t       s2_mdv_q [3];
  mag_t       s2_den_q [3];
  mag_t       s2_dxm_q [3];
  mag_t       s2_dym_q [3];
  logic [2:0] s2_below_q, s2_sx_q, s2_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pz_q <= s1_pz_q;
      for (int k = 0; k < 3; k++) begin
        s2_v_q[k]     <= s1_v_q[k];
        s2_mdv_q[k]   <= abs_diff(s1_v_q[k].z, s1_pz_q);
        s2_below_q[k] <= $signed(s1_v_q[k].z) < $signed(s1_pz_q);
        s2_den_q[k]   <= abs_diff(s1_v_q[k].z, s1_v_q[next_vtx(k)].z);
        s2_dxm_q[k]   <= abs_diff(s1_v_q[next_vtx(k)].x, s1_v_q[k].x);
        s2_dym_q[k]   <= abs_diff(s1_v_q[next_vtx(k)].y, s1_v_q[k].y);
        s2_sx_q[k]    <= $signed(s1_v_q[next_vtx(k)].x) >= $signed(s1_v_q[k].x);
        s2_sy_q[k]    <= $signed(s1_v_q[next_vtx(k)].y) >= $signed(s1_v_q[k].y);
      end
    end
  end

  // stage 3: on-plane flags and interpolation numerators
  carry_t           s3_carry_q;
  logic [ProdW-1:0] s3_numx_q [3];
  logic [ProdW-1:0] s3_numy_q [3];
  mag_t             s3_den_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_carry_q.pz    <= s2_pz_q;
      s3_carry_q.below <= s2_below_q;
      s3_carry_q.sx    <= s2_sx_q;
      s3_carry_q.sy    <= s2_sy_q;
      for (int k = 0; k < 3; k++) begin
        s3_carry_q.v[k]  <= s2_v_q[k];
        s3_carry_q.on[k] <= s2_mdv_q[k] <= MagW'(tol_q);
        s3_numx_q[k]     <= s2_dxm_q[k] * s2_mdv_q[k];
        s3_numy_q[k]     <= s2_dym_q[k] * s2_mdv_q[k];
        s3_den_q[k]      <= s2_den_q[k];
      end
    end
  end

  // divider stages: interpolation offsets for x and y of every edge
  mag_t   qx [3];
  mag_t   qy [3];
  carry_t dcar_q [DivSteps];

  for (genvar e = 0; e < 3; e++) begin : g_div
    tpss_div_pipe #(.Width(MagW)) u_div_x (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s3_numx_q[e]),
      .den_i (s3_den_q[e]),
      .quo_o (qx[e])
    );
    tpss_div_pipe #(.Width(MagW)) u_div_y (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (s3_numy_q[e]),
      .den_i (s3_den_q[e]),
      .quo_o (qy[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dcar_q[0] <= s3_carry_q;
      for (int k = 1; k < DivSteps; k++) begin
        dcar_q[k] <= dcar_q[k-1];
      end
    end
  end

  // stage 4: one candidate point per edge
  carry_t     dc;
  point_t     cand_d [3];
  logic [2:0] cval_d;
  point_t     s4_cand_q [3];
  logic [2:0] s4_val_q;

  assign dc = dcar_q[DivSteps-1];

  always_comb begin
    point_t cross_pt;
    for (int e = 0; e < 3; e++) begin
      cross_pt.x = dc.sx[e] ? dc.v[e].x + qx[e] : dc.v[e].x - qx[e];
      cross_pt.y = dc.sy[e] ? dc.v[e].y + qy[e] : dc.v[e].y - qy[e];
      cross_pt.z = dc.pz;
      cand_d[e] = cross_pt;
      cval_d[e] = 1'b0;
      if (dc.on[e] && !dc.on[next_vtx(e)]) begin
        cand_d[e] = dc.v[e];
        cval_d[e] = 1'b1;
      end else if (dc.on[next_vtx(e)] && !dc.on[e]) begin
        cand_d[e] = dc.v[next_vtx(e)];
        cval_d[e] = 1'b1;
      end else if (!dc.on[e] && !dc.on[next_vtx(e)] &&
                   (dc.below[e] != dc.below[next_vtx(e)])) begin
        cval_d[e] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_cand_q <= cand_d;
      s4_val_q  <= cval_d;
    end
  end

  // stage 5: per-axis distances of the three candidate pairs
  mag_t       s5_dx_q [3];
  mag_t       s5_dy_q [3];
  mag_t       s5_dz_q [3];
  point_t     s5_cand_q [3];
  logic [2:0] s5_val_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_cand_q <= s4_cand_q;
      s5_val_q  <= s4_val_q;
      for (int p = 0; p < 3; p++) begin
        s5_dx_q[p] <= abs_diff(s4_cand_q[pair_first(p)].x, s4_cand_q[pair_second(p)].x);
        s5_dy_q[p] <= abs_diff(s4_cand_q[pair_first(p)].y, s4_cand_q[pair_second(p)].y);
        s5_dz_q[p] <= abs_diff(s4_cand_q[pair_first(p)].z, s4_cand_q[pair_second(p)].z);
      end
    end
  end

  // stage 6: squares
  logic [ProdW-1:0] s6_sqx_q [3];
  logic [ProdW-1:0] s6_sqy_q [3];
  logic [ProdW-1:0] s6_sqz_q [3];
  point_t           s6_cand_q [3];
  logic [2:0]       s6_val_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_cand_q <= s5_cand_q;
      s6_val_q  <= s5_val_q;
      for (int p = 0; p < 3; p++) begin
        s6_sqx_q[p] <= s5_dx_q[p] * s5_dx_q[p];
        s6_sqy_q[p] <= s5_dy_q[p] * s5_dy_q[p];
        s6_sqz_q[p] <= s5_dz_q[p] * s5_dz_q[p];
      end
    end
  end

  // stage 7: squared pair distances
  logic [SumW-1:0] s7_sum_q [3];
  point_t          s7_cand_q [3];
  logic [2:0]      s7_val_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_cand_q <= s6_cand_q;
      s7_val_q  <= s6_val_q;
      for (int p = 0; p < 3; p++) begin
        s7_sum_q[p] <= SumW'(s6_sqx_q[p]) + SumW'(s6_sqy_q[p]) + SumW'(s6_sqz_q[p]);
      end
    end
  end

  // stage 8: distance compares against tolerance and each other
  logic [2:0] s8_lt_q, s8_gtt_q, s8_nz_q;
  logic       s8_g02_01_q, s8_g12_01_q, s8_g12_02_q;
  point_t     s8_cand_q [3];
  logic [2:0] s8_val_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_cand_q   <= s7_cand_q;
      s8_val_q    <= s7_val_q;
      s8_g02_01_q <= s7_sum_q[PAIR_02] > s7_sum_q[PAIR_01];
      s8_g12_01_q <= s7_sum_q[PAIR_12] > s7_sum_q[PAIR_01];
      s8_g12_02_q <= s7_sum_q[PAIR_12] > s7_sum_q[PAIR_02];
      for (int p = 0; p < 3; p++) begin
        s8_lt_q[p]  <= s7_sum_q[p] < SumW'(tol2_q);
        s8_gtt_q[p] <= s7_sum_q[p] > SumW'(tol2_q);
        s8_nz_q[p]  <= s7_sum_q[p] != '0;
      end
    end
  end

  // stage 9: duplicate removal, farthest pair and endpoint select
  logic   hit_d;
  pair_e  sel_d;
  coord_t s9_c_q [4];
  logic   s9_hit_q;

  always_comb begin
    logic a0, a1, a2, take01, take02, take12;
    a0     = s8_val_q[0];
    a1     = s8_val_q[1] && !(a0 && s8_lt_q[PAIR_01]);
    a2     = s8_val_q[2] && !(a0 && s8_lt_q[PAIR_02]) && !(a1 && s8_lt_q[PAIR_12]);
    take01 = a0 && a1 && s8_nz_q[PAIR_01];
    take02 = a0 && a2 && (take01 ? s8_g02_01_q : s8_nz_q[PAIR_02]);
    take12 = a1 && a2 && (take02 ? s8_g12_02_q :
                          (take01 ? s8_g12_01_q : s8_nz_q[PAIR_12]));
    sel_d = PAIR_01;
    hit_d = 1'b0;
    if (take12) begin
      sel_d = PAIR_12;
      hit_d = s8_gtt_q[PAIR_12];
    end else if (take02) begin
      sel_d = PAIR_02;
      hit_d = s8_gtt_q[PAIR_02];
    end else if (take01) begin
      sel_d = PAIR_01;
      hit_d = s8_gtt_q[PAIR_01];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_hit_q <= hit_d;
      s9_c_q[0] <= s8_cand_q[pair_first(int'(sel_d))].x;
      s9_c_q[1] <= s8_cand_q[pair_first(int'(sel_d))].y;
      s9_c_q[2] <= s8_cand_q[pair_second(int'(sel_d))].x;
      s9_c_q[3] <= s8_cand_q[pair_second(int'(sel_d))].y;
    end
  end

  // stage 10: scale to pixels
  logic signed [MapW-1:0] s10_p_q [4];
  logic                   s10_hit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_hit_q <= s9_hit_q;
      for (int k = 0; k < 4; k++) begin
        s10_p_q[k] <= $signed(s9_c_q[k]) * $signed({1'b0, ppm_q});
      end
    end
  end

  // stage 11: centre, flip rows, saturate
  function automatic coord_t sat32(logic signed [RW-1:0] r);
    if (r > SatHi) begin
      return 32'h7fff_ffff;
    end else if (r < SatLo) begin
      return 32'h8000_0000;
    end
    return r[CoordW-1:0];
  endfunction

  logic [OffW-1:0]        col_off, row_off;
  logic signed [RW-1:0]   px_r [4];
  coord_t                 out_c_q [4];
  logic                   out_hit_q;

  assign col_off = {width_q, {(FRAC_BITS-1){1'b0}}};
  assign row_off = {height_q, {(FRAC_BITS-1){1'b0}}};

  always_comb begin
    logic signed [RW-1:0] v;
    for (int k = 0; k < 4; k++) begin
      v = RW'($signed(s10_p_q[k][MapW-1:PpmFrac]));
      if (k == 0 || k == 2) begin
        px_r[k] = $signed(RW'(col_off)) + v;
      end else begin
        px_r[k] = $signed(RW'(row_off)) - v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= s10_hit_q;
      for (int k = 0; k < 4; k++) begin
        out_c_q[k] <= s10_hit_q ? sat32(px_r[k]) : '0;
      end
    end
  end

  assign hit_o       = out_hit_q;
  assign start_col_o = out_c_q[0];
  assign start_row_o = out_c_q[1];
  assign end_col_o   = out_c_q[2];
  assign end_row_o   = out_c_q[3];

  // checks
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> start_col_o == 0 && start_row_o == 0 &&
                              end_col_o == 0 && end_row_o == 0)
    else $error("no-hit result carries nonzero coordinates");

  a_hit_two_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Latency-4] && hit_d |-> $countones(s8_val_q) >= 2)
    else $error("segment found with fewer than two candidate points");

  a_tol_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tol2_q == tol_q * tol_q)
    else $error("squared tolerance out of step with tolerance");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

endmodule

>>> bench/tb_triangle_plane_slice_segment_unit.sv
// testbench for the triangle plane slice segment unit: queued stimulus, predictor, checker
module tb_triangle_plane_slice_segment_unit import tpss_pkg::*;;

  typedef struct {
    point_t v [3];
    coord_t pz;
  } tri_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] start_col;
    logic [31:0] start_row;
    logic [31:0] end_col;
    logic [31:0] end_row;
  } seg_t;

  localparam longint MagCap = 64'd1 << 50;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  coord_t vertex_a_x_i, vertex_a_y_i, vertex_a_z_i;
  coord_t vertex_b_x_i, vertex_b_y_i, vertex_b_z_i;
  coord_t vertex_c_x_i, vertex_c_y_i, vertex_c_z_i;
  coord_t plane_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic hit_o;
  logic signed [31:0] start_col_o, start_row_o, end_col_o, end_row_o;

  // register shadow
  logic [31:0] ppm_r;
  logic [14:0] width_r;
  logic [14:0] height_r;
  logic [15:0] tol_r;

  tri_t pending_tris [$];
  seg_t expected_segs [$];
  tri_t tri_cur;
  int   err_count;
  int   send_gap;
  int   send_burst;
  int   recv_gap;
  int   recv_burst;
  bit   fire;
  seg_t got;
  seg_t want;

  triangle_plane_slice_segment_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .vertex_a_x_i, .vertex_a_y_i, .vertex_a_z_i,
    .vertex_b_x_i, .vertex_b_y_i, .vertex_b_z_i,
    .vertex_c_x_i, .vertex_c_y_i, .vertex_c_z_i,
    .plane_z_i,
    .out_valid_o, .out_ready_i,
    .hit_o, .start_col_o, .start_row_o, .end_col_o, .end_row_o
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic logic [127:0] sq_dist(longint ax, longint ay, longint az,
                                           longint bx, longint by, longint bz);
    logic [127:0] dx, dy, dz;
    dx = 128'(mag(ax - bx));
    dy = 128'(mag(ay - by));
    dz = 128'(mag(az - bz));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // crossing coordinate, quotient magnitude truncated
  function automatic longint cross_coord(longint a, longint b, longint mda, longint den);
    logic [127:0] prod;
    longint q;
    prod = 128'(mag(b - a)) * 128'(mda);
    q = longint'(prod / 128'(den));
    return (b >= a) ? a + q : a - q;
  endfunction

  // mm to pixel, Q16.16 out, saturated
  function automatic logic [31:0] to_pix(longint c, longint size, bit flip);
    logic [127:0] p;
    longint m, s, v, off, r;
    m = mag(c);
    p = 128'(m) * 128'(ppm_r);
    s = longint'(p >> 16);
    if ((p >> 80) != 0 || s > MagCap) s = MagCap;
    else if (c < 0 && p[15:0] != 0) s = s + 1;
    v = (c < 0) ? -s : s;
    off = size * 32768;
    r = flip ? off - v : off + v;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // farthest intersection pair of a triangle with the plane
  function automatic seg_t slice_triangle(tri_t t);
    longint vx [3], vy [3], vz [3];
    longint lx [6], ly [6], lz [6];
    longint cx [3], cy [3], cz [3];
    longint plane, mda, mdb, den, tol;
    logic [127:0] tol2, best, d;
    int n, nc, a, b, ba, bb;
    bit ona, onb, dup;
    seg_t r;
    r = '0;
    n = 0;
    tol = longint'(tol_r);
    tol2 = 128'(tol_r) * 128'(tol_r);
    plane = longint'(t.pz);
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'($signed(t.v[i][95:64]));
      vy[i] = longint'($signed(t.v[i][63:32]));
      vz[i] = longint'($signed(t.v[i][31:0]));
    end
    for (int e = 0; e < 3; e++) begin
      a = e;
      b = (e == 2) ? 0 : e + 1;
      mda = mag(vz[a] - plane);
      mdb = mag(vz[b] - plane);
      ona = mda <= tol;
      onb = mdb <= tol;
      if (ona && onb) continue;
      nc = 0;
      if (ona) begin
        cx[nc] = vx[a]; cy[nc] = vy[a]; cz[nc] = vz[a]; nc++;
      end
      if (!ona && !onb && ((vz[a] < plane) != (vz[b] < plane))) begin
        den = mag(vz[a] - vz[b]);
        cx[nc] = cross_coord(vx[a], vx[b], mda, den);
        cy[nc] = cross_coord(vy[a], vy[b], mda, den);
        cz[nc] = cross_coord(vz[a], vz[b], mda, den);
        nc++;
      end
      if (onb) begin
        cx[nc] = vx[b]; cy[nc] = vy[b]; cz[nc] = vz[b]; nc++;
      end
      // drop points closer than the tolerance to a listed one
      for (int k = 0; k < nc; k++) begin
        dup = 0;
        for (int j = 0; j < n; j++)
          if (sq_dist(lx[j], ly[j], lz[j], cx[k], cy[k], cz[k]) < tol2) dup = 1;
        if (!dup && n < 6) begin
          lx[n] = cx[k]; ly[n] = cy[k]; lz[n] = cz[k]; n++;
        end
      end
    end
    if (n < 2) return r;
    best = '0;
    ba = 0;
    bb = 1;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        d = sq_dist(lx[i], ly[i], lz[i], lx[j], ly[j], lz[j]);
        if (d > best) begin
          best = d; ba = i; bb = j;
        end
      end
    if (best <= tol2) return r;
    r.hit = 1'b1;
    r.start_col = to_pix(lx[ba], longint'(width_r), 0);
    r.start_row = to_pix(ly[ba], longint'(height_r), 1);
    r.end_col = to_pix(lx[bb], longint'(width_r), 0);
    r.end_row = to_pix(ly[bb], longint'(height_r), 1);
    return r;
  endfunction

  function automatic tri_t mk_tri(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                                  coord_t bz, coord_t cx, coord_t cy, coord_t cz, coord_t pz);
    tri_t t;
    t.v[0] = {ax, ay, az};
    t.v[1] = {bx, by, bz};
    t.v[2] = {cx, cy, cz};
    t.pz = pz;
    return t;
  endfunction

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      1: return coord_t'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // height near the plane, falling back to random when it would wrap
  function automatic coord_t near_z(coord_t pz);
    longint off, z;
    case ($urandom_range(0, 9))
      0: off = 0;
      1, 2: off = longint'($urandom_range(0, 2 * tol_r + 4)) - tol_r - 2;
      3, 4, 5: off = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
      6, 7: off = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
      default: off = longint'($signed($urandom));
    endcase
    z = longint'(pz) + off;
    if (z > 64'sd2147483647 || z < -64'sd2147483648) return coord_t'($urandom);
    return coord_t'(z);
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    int k;
    k = $urandom_range(0, 99);
    t.pz = rnd_coord();
    for (int i = 0; i < 3; i++)
      t.v[i] = {rnd_coord(), rnd_coord(), (k < 80) ? near_z(t.pz) : rnd_coord()};
    // repeated vertices and flat triangles
    if (k >= 90) t.v[$urandom_range(0, 2)] = t.v[$urandom_range(0, 2)];
    if (k >= 95) for (int i = 0; i < 3; i++) t.v[i][31:0] = t.pz;
    return t;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sender: present queued triangles, predict on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      send_burst <= 0;
    end else begin
      fire = in_valid_i && in_ready_o;
      if (fire) expected_segs.push_back(slice_triangle(tri_cur));
      if (!in_valid_i || fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_tris.size() > 0) begin
          tri_cur = pending_tris.pop_front();
          {vertex_a_x_i, vertex_a_y_i, vertex_a_z_i} <= tri_cur.v[0];
          {vertex_b_x_i, vertex_b_y_i, vertex_b_z_i} <= tri_cur.v[1];
          {vertex_c_x_i, vertex_c_y_i, vertex_c_z_i} <= tri_cur.v[2];
          plane_z_i <= tri_cur.pz;
          in_valid_i <= 1'b1;
          if (send_burst > 0) begin
            send_burst <= send_burst - 1;
            send_gap <= 0;
          end else begin
            send_gap <= pick_gap();
            if ($urandom_range(0, 49) == 0) send_burst <= $urandom_range(20, 80);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, compare each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
      recv_burst <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = {hit_o, start_col_o, start_row_o, end_col_o, end_row_o};
        if (expected_segs.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected: hit %0d cols %0d %0d rows %0d %0d",
                   $time, got.hit, $signed(got.start_col), $signed(got.end_col),
                   $signed(got.start_row), $signed(got.end_row));
        end else begin
          want = expected_segs.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: mismatch expected hit %0d sc %0d sr %0d ec %0d er %0d", $time,
                     want.hit, $signed(want.start_col), $signed(want.start_row),
                     $signed(want.end_col), $signed(want.end_row));
            $display("%0t:          actual   hit %0d sc %0d sr %0d ec %0d er %0d", $time,
                     got.hit, $signed(got.start_col), $signed(got.start_row),
                     $signed(got.end_col), $signed(got.end_row));
          end
        end
      end
      if (recv_burst > 0) begin
        recv_burst <= recv_burst - 1;
        out_ready_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap <= pick_gap();
        if ($urandom_range(0, 49) == 0) recv_burst <= $urandom_range(20, 80);
      end
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PIXELS_PER_MM:   ppm_r = data;
      CFG_IMAGE_WIDTH:     width_r = data[14:0];
      CFG_IMAGE_HEIGHT:    height_r = data[14:0];
      CFG_PLANE_TOLERANCE: tol_r = data[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_tris.size() == 0 && !in_valid_i && expected_segs.size() == 0);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic random_tris(int count);
    for (int i = 0; i < count; i++) pending_tris.push_back(rnd_tri());
  endtask

  // stimulus and configuration phases
  initial begin
    err_count = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PIXELS_PER_MM;
    cfg_data_i = '0;
    ppm_r = PpmReset;
    width_r = DimReset;
    height_r = DimReset;
    tol_r = TolReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed triangles at reset settings
    // flat on the plane, crossing, vertex touch, edge on plane, single touch, miss
    pending_tris.push_back(mk_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0));
    pending_tris.push_back(mk_tri(0, 0, -65536, 65536, 0, 65536, 0, 65536, 65536, 0));
    pending_tris.push_back(mk_tri(100, 200, 0, 70000, -3000, 90000, -5000, 4000, -80000, 0));
    pending_tris.push_back(mk_tri(-65536, 0, 500, 65536, 0, 500, 0, 99999, 90000, 500));
    pending_tris.push_back(mk_tri(7, 8, 0, 9, 10, 50000, 11, 12, 60000, 0));
    pending_tris.push_back(mk_tri(1, 2, 3000, 4, 5, 6000, 7, 8, 9000, -1));
    // extremes of every field
    pending_tris.push_back(mk_tri(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                                  0, 0, 32'sh7fffffff, 0));
    pending_tris.push_back(mk_tri(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                  -1, -1, -1, 32'sh7fffffff));
    pending_tris.push_back(mk_tri(-1, -1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                  32'sh80000000, 32'sh80000000));
    // crossing point coincides with the vertex on the plane
    pending_tris.push_back(mk_tri(0, 0, 0, 0, 0, 65536, 0, 0, -65536, 0));
    // ends within the tolerance of the plane
    pending_tris.push_back(mk_tri(3, 4, 1, 900, -900, -1, 50, 60, 5, 0));
    // negative fractions exercise rounding of the mapping
    pending_tris.push_back(mk_tri(-12345, -54321, -3, -1, -7, 9, 333, -1, -9, 0));
    // coincident vertices
    pending_tris.push_back(mk_tri(10, 10, 0, 10, 10, 0, 10, 10, 70000, 0));
    pending_tris.push_back(mk_tri(5, 6, -70000, 5, 6, -70000, 9, 9, 70000, 0));
    random_tris(180);
    // wait until every result is back before queuing more
    wait (pending_tris.size() == 0 && !in_valid_i && expected_segs.size() == 0);
    random_tris(180);
    drain();

    // smallest settings, zero tolerance
    cfg_write(CFG_PIXELS_PER_MM, 32'd1);
    cfg_write(CFG_IMAGE_WIDTH, 32'd1);
    cfg_write(CFG_IMAGE_HEIGHT, 32'd1);
    cfg_write(CFG_PLANE_TOLERANCE, 32'd0);
    random_tris(380);
    drain();

    // largest scale and tolerance, 16384 by 16384 image
    cfg_write(CFG_PIXELS_PER_MM, 32'hffffffff);
    cfg_write(CFG_IMAGE_WIDTH, 32'd16384);
    cfg_write(CFG_IMAGE_HEIGHT, 32'd16384);
    cfg_write(CFG_PLANE_TOLERANCE, 32'd65535);
    random_tris(380);
    drain();

    // zero scale maps every point to the centre
    cfg_write(CFG_PIXELS_PER_MM, 32'd0);
    cfg_write(CFG_IMAGE_WIDTH, 32'd640);
    cfg_write(CFG_IMAGE_HEIGHT, 32'd480);
    cfg_write(CFG_PLANE_TOLERANCE, 32'd100);
    random_tris(380);
    drain();

    // random mid-range settings
    cfg_write(CFG_PIXELS_PER_MM, $urandom_range(1, 32'h00400000));
    cfg_write(CFG_IMAGE_WIDTH, $urandom_range(1, 16384));
    cfg_write(CFG_IMAGE_HEIGHT, $urandom_range(1, 16384));
    cfg_write(CFG_PLANE_TOLERANCE, $urandom_range(0, 4096));
    random_tris(380);
    drain();

    if (err_count == 0 && expected_segs.size() == 0) begin
      $display("tb_triangle_plane_slice_segment_unit: clean");
    end else begin
      $display("tb_triangle_plane_slice_segment_unit: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("tb_triangle_plane_slice_segment_unit: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/tpss_pkg.sv
rtl/tpss_div_pipe.sv
rtl/triangle_plane_slice_segment_unit.sv
bench/tb_triangle_plane_slice_segment_unit.sv
